// ===== hdl/modular_exponentiation_top_macros.svh =====
// Assertion macros shared by the modular exponentiation RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MEXP_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MEXP_ASSERT(name, clk, rstn, prop, msg)
`define MEXP_NEVER(name, clk, rstn, cond, msg)
`endif
`endif

// ===== hdl/modexp_pkg.sv =====
// Package for the modular exponentiation block: field widths, defaults,
// operation codes and the controller/datapath command and status types.
`default_nettype none
package modexp_pkg;

  localparam int BASE_W        = 32;
  localparam int EXP_FIELD_W   = 63;
  localparam int EXP_WIDE_W    = 64;
  localparam int IN_DATA_W     = 96;
  localparam int POWER_W       = 32;
  localparam int OUT_DATA_W    = 32;
  localparam int CFG_W         = 32;
  localparam int MOD_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF = 63;
  localparam int CNT_W         = $clog2(BASE_W);

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MULT,
    OP_SQUARE
  } op_e;

  typedef struct packed {
    logic load;
    logic start;
    op_e  opsel;
    logic wr_acc;
    logic wr_sq;
    logic shift;
    logic result_wr;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/modexp_mul.sv =====
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on modexp_pkg and the assertion macro header.
`default_nettype none
`include "modular_exponentiation_top_macros.svh"
module modexp_mul #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [modexp_pkg::BASE_W-1:0] a_i,
  input  wire logic [MOD_WIDTH-1:0]          b_i,
  input  wire logic [MOD_WIDTH-1:0]          mod_i,
  output logic                               done_o,
  output logic [MOD_WIDTH-1:0]               p_o
);

  localparam int SW = MOD_WIDTH + 2;
  localparam int AW = modexp_pkg::BASE_W;
  localparam int CW = modexp_pkg::CNT_W;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        a_q, a_d;
  logic [MOD_WIDTH-1:0] b_q, b_d;
  logic [MOD_WIDTH-1:0] r_q, r_d;

  logic [SW-1:0] sum, m1, m2, diff1, diff2;
  logic [MOD_WIDTH-1:0] r_step;

  always_comb begin
    m1    = SW'(mod_i);
    m2    = SW'({mod_i, 1'b0});
    sum   = SW'({r_q, 1'b0}) + (a_q[AW-1] ? SW'(b_q) : '0);
    diff1 = sum - m1;
    diff2 = sum - m2;
    if (mod_i == '0) begin
      r_step = sum[MOD_WIDTH-1:0];
    end else if (sum >= m2) begin
      r_step = diff2[MOD_WIDTH-1:0];
    end else if (sum >= m1) begin
      r_step = diff1[MOD_WIDTH-1:0];
    end else begin
      r_step = sum[MOD_WIDTH-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = r_step;
      a_d   = {a_q[AW-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(AW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign p_o    = r_q;

  `MEXP_NEVER(a_start_idle, clk_i, rst_ni, start_i && busy_q, "Multiply started while busy.")
  `MEXP_ASSERT(a_busy_rise, clk_i, rst_ni, $rose(busy_q) |-> $past(start_i), "Busy without a start.")
  `MEXP_ASSERT(a_done_end, clk_i, rst_ni, $fell(busy_q) |-> done_q, "Multiply ended without done.")

endmodule
`default_nettype wire

// ===== hdl/modexp_dp.sv =====
// Datapath: modulus register, accumulator, square, exponent shifter, result register.
// Depends on modexp_pkg and instantiates modexp_mul.
`default_nettype none
module modexp_dp #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [modexp_pkg::IN_DATA_W-1:0]  in_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [modexp_pkg::OUT_DATA_W-1:0]      out_data_o,
  input  wire logic                              cfg_valid_i,
  input  wire logic [modexp_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire modexp_pkg::cmd_t                  cmd_i,
  output modexp_pkg::sts_t                       sts_o
);

  logic [MOD_WIDTH-1:0] mod_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] sq_q;
  logic [EXP_WIDTH-1:0] exp_q;
  logic [MOD_WIDTH-1:0] power_q;
  logic                 out_valid_q;

  logic [modexp_pkg::BASE_W-1:0]     mul_a;
  logic [MOD_WIDTH-1:0]              mul_b;
  logic [MOD_WIDTH-1:0]              mul_p;
  logic                              mul_done;
  logic [modexp_pkg::EXP_WIDE_W-1:0] exp_wide;

  assign exp_wide = {1'b0, in_data_i[modexp_pkg::BASE_W +: modexp_pkg::EXP_FIELD_W]};

  always_comb begin
    case (cmd_i.opsel)
      modexp_pkg::OP_MULT: begin
        mul_a = modexp_pkg::BASE_W'(acc_q);
        mul_b = sq_q;
      end
      modexp_pkg::OP_SQUARE: begin
        mul_a = modexp_pkg::BASE_W'(sq_q);
        mul_b = sq_q;
      end
      default: begin
        mul_a = in_data_i[modexp_pkg::BASE_W-1:0];
        mul_b = MOD_WIDTH'(1);
      end
    endcase
  end

  modexp_mul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .mod_i  (mod_q),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MOD_WIDTH'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mod_q <= cfg_data_i[MOD_WIDTH-1:0];
      end
      if (cmd_i.result_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= MOD_WIDTH'(1);
      exp_q <= exp_wide[EXP_WIDTH-1:0];
    end else begin
      if (cmd_i.wr_acc) begin
        acc_q <= mul_p;
      end
      if (cmd_i.shift) begin
        exp_q <= exp_q >> 1;
      end
    end
    if (cmd_i.wr_sq) begin
      sq_q <= mul_p;
    end
    if (cmd_i.result_wr) begin
      power_q <= acc_q;
    end
  end

  always_comb begin
    sts_o.mul_done      = mul_done;
    sts_o.exp_zero      = (exp_q == '0);
    sts_o.exp_lsb       = exp_q[0];
    sts_o.exp_rest_zero = ((exp_q >> 1) == '0);
    sts_o.out_busy      = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = modexp_pkg::OUT_DATA_W'(power_q);

endmodule
`default_nettype wire

// ===== hdl/modexp_ctrl.sv =====
// Controller state machine sequencing the square-and-multiply steps.
// Depends on modexp_pkg and the assertion macro header.
`default_nettype none
`include "modular_exponentiation_top_macros.svh"
module modexp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire modexp_pkg::sts_t sts_i,
  output modexp_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_MULT,
    S_SQUARE,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.opsel = modexp_pkg::OP_REDUCE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.start = 1'b1;
          state_d     = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts_i.mul_done) begin
          cmd_o.wr_sq = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.exp_zero) begin
          state_d = S_DONE;
        end else if (sts_i.exp_lsb) begin
          cmd_o.start = 1'b1;
          cmd_o.opsel = modexp_pkg::OP_MULT;
          state_d     = S_MULT;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.opsel = modexp_pkg::OP_SQUARE;
          state_d     = S_SQUARE;
        end
      end
      S_MULT: begin
        if (sts_i.mul_done) begin
          cmd_o.wr_acc = 1'b1;
          if (sts_i.exp_rest_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.opsel = modexp_pkg::OP_SQUARE;
            state_d     = S_SQUARE;
          end
        end
      end
      S_SQUARE: begin
        if (sts_i.mul_done) begin
          cmd_o.wr_sq = 1'b1;
          cmd_o.shift = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.result_wr = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  `MEXP_NEVER(a_done_state, clk_i, rst_ni, sts_i.mul_done && (state_q == S_IDLE || state_q == S_CHECK || state_q == S_DONE), "Multiply finished with no step pending.")
  `MEXP_NEVER(a_result_free, clk_i, rst_ni, cmd_o.result_wr && sts_i.out_busy, "Result written over a pending one.")
  `MEXP_ASSERT(a_accept_reduce, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_REDUCE), "Accepted request did not start base reduction.")

endmodule
`default_nettype wire

// ===== hdl/modular_exponentiation_top.sv =====
// Modular exponentiation of a streamed base and exponent by a configured modulus.
// Each request starts with a reduction of the base; then each exponent bit up to the
// highest set one takes a square if it is clear and a multiply and a square if it is
// set (the highest set bit takes only the multiply). All products come from the one
// shared bit-serial modular multiplier. One request is worked on at a time; a new
// request is taken while the previous result still waits on the output. A zero exponent
// gives 1, and a modulus of zero acts as 2 to the power MOD_WIDTH. The modulus resets
// to 1. The user must write it only while the block is idle; the block itself does not
// enforce this.
// Depends on modexp_pkg, modexp_ctrl and modexp_dp.
`default_nettype none
module modular_exponentiation_top #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // Fields from bit 0: base (32 bits), exponent (63 bits), one zero pad bit.
  input  wire logic [modexp_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // Fields from bit 0: power (32 bits).
  output logic [modexp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [modexp_pkg::CFG_W-1:0]      cfg_data_i
);

  modexp_pkg::cmd_t cmd;
  modexp_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  modexp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  modexp_dp #(
    .MOD_WIDTH(MOD_WIDTH),
    .EXP_WIDTH(EXP_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_data_o (m_axis_tdata_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
`default_nettype wire
